[rtl/core/dnle_pkg.sv]
// Shared constants and types for the DNS name label encoder.
package dnle_pkg;

  localparam int unsigned MAX_LABEL   = 63;
  localparam int unsigned STORE_DEPTH = 63;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] END_CHAR = 8'h00;

  typedef struct packed {
    logic       last;
    logic       label_error;
    logic       second_valid;
    logic [7:0] second_byte;
    logic [7:0] first_byte;
  } res_t;

  // Controller -> datapath
  typedef struct packed {
    logic wr_char;     // buffer the accepted character
    logic emit_start;  // load length byte, prefetch first character
    logic emit_char;   // load buffered character
    logic emit_err;    // load overlong-label error result
    logic emit_term;   // load lone terminator result
    logic clr_count;   // drop the buffered label
    logic final_char;  // character result carries the terminator
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_end;
    logic is_dot;
    logic cnt_zero;
    logic cnt_full;
    logic idx_last;
    logic out_can_load;
  } sts_t;

endpackage

[rtl/core/dnle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dnle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/dnle_dp.sv]
// Datapath: label count, label buffer, read index and output register.
module dnle_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      char_i,
  input  dnle_pkg::cmd_t  cmd_i,
  output dnle_pkg::sts_t  sts_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output dnle_pkg::res_t  out_res_o
);
  import dnle_pkg::*;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              idx_last;
  logic              any_load;

  assign idx_last = (idx_q == (cnt_q - CNT_W'(1)));
  assign any_load = cmd_i.emit_start | cmd_i.emit_char | cmd_i.emit_err | cmd_i.emit_term;

  // Next character is prefetched whenever the length byte or a character other than the
  // label's last is loaded, so the registered read data is ready for the following cycle.
  assign rd_en   = cmd_i.emit_start | (cmd_i.emit_char & ~idx_last);
  assign rd_addr = cmd_i.emit_start ? '0 : ADDR_W'(idx_q + CNT_W'(1));

  dnle_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.wr_char),
    .wr_addr_i(ADDR_W'(cnt_q)),
    .wr_data_i(char_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clr_count) begin
      cnt_d = '0;
    end else if (cmd_i.wr_char) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.emit_start) begin
      idx_d = '0;
    end else if (cmd_i.emit_char && !idx_last) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.emit_start) begin
      res_d = '0;
      res_d.first_byte = 8'(cnt_q);
    end else if (cmd_i.emit_char) begin
      res_d = '0;
      res_d.first_byte   = rd_data;
      res_d.second_valid = cmd_i.final_char;
      res_d.last         = cmd_i.final_char;
    end else if (cmd_i.emit_err) begin
      res_d = '0;
      res_d.label_error = 1'b1;
      res_d.last        = 1'b1;
    end else if (cmd_i.emit_term) begin
      res_d = '0;
      res_d.last = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (any_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign sts_o.is_end       = (char_i == END_CHAR);
  assign sts_o.is_dot       = (char_i == DOT_CHAR);
  assign sts_o.cnt_zero     = (cnt_q == '0);
  assign sts_o.cnt_full     = (cnt_q >= CNT_W'(MAX_LABEL));
  assign sts_o.idx_last     = idx_last;
  assign sts_o.out_can_load = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

[rtl/core/dnle_ctrl.sv]
// Controller: accept/emit state machine and discard flag.
module dnle_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dnle_pkg::sts_t sts_i,
  output dnle_pkg::cmd_t cmd_o
);
  import dnle_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q, state_d;
  logic disc_q, disc_d;
  logic ending_q, ending_d;
  logic acc;

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.out_can_load;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    disc_d   = disc_q;
    ending_d = ending_q;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (disc_q) begin
            if (sts_i.is_end) begin
              disc_d          = 1'b0;
              cmd_o.clr_count = 1'b1;
            end
          end else if (sts_i.is_end) begin
            if (sts_i.cnt_zero) begin
              cmd_o.emit_term = 1'b1;
            end else begin
              cmd_o.emit_start = 1'b1;
              ending_d         = 1'b1;
              state_d          = ST_EMIT;
            end
          end else if (sts_i.is_dot) begin
            if (!sts_i.cnt_zero) begin
              cmd_o.emit_start = 1'b1;
              ending_d         = 1'b0;
              state_d          = ST_EMIT;
            end
          end else if (sts_i.cnt_full) begin
            cmd_o.emit_err  = 1'b1;
            cmd_o.clr_count = 1'b1;
            disc_d          = 1'b1;
          end else begin
            cmd_o.wr_char = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_can_load) begin
          cmd_o.emit_char  = 1'b1;
          cmd_o.final_char = ending_q & sts_i.idx_last;
          if (sts_i.idx_last) begin
            cmd_o.clr_count = 1'b1;
            state_d         = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      disc_q   <= 1'b0;
      ending_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      disc_q   <= disc_d;
      ending_q <= ending_d;
    end
  end

endmodule

[rtl/core/dns_name_label_encoder_top.sv]
// Top level of the DNS name label encoder.
//
//  Channel  Dir  Signals                    Contents (low bit up)
//  s_axis   in   tvalid tready tdata[7:0]   character
//  m_axis   out  tvalid tready tdata[15:0]  first_byte, second_byte
//                tuser[1:0] tlast           second_valid, label_error; last
//
// A dot or zero closing a label of n characters starts n+1 results that leave
// at one per cycle unless the output stalls (length byte, then one read per
// cycle from the label RAM, prefetched one ahead); input is held off until the
// last is loaded. While a result is stalled in the output register, no
// character is accepted. Reset clears count, discard flag and output valid;
// the label RAM is not cleared. m_axis_tready low with a result held stalls
// result loading and input acceptance.
module dns_name_label_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] first_byte, [15:8] second_byte
  output logic [1:0]  m_axis_tuser,   // [0] second_valid, [1] label_error
  output logic        m_axis_tlast
);
  import dnle_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;

  dnle_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dnle_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_i     (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_res_o  (res)
  );

  assign m_axis_tdata = {res.second_byte, res.first_byte};
  assign m_axis_tuser = {res.label_error, res.second_valid};
  assign m_axis_tlast = res.last;

endmodule

[rtl/core/dnle_chk.sv]
// Port-level checker for the DNS name label encoder, bound to the top level.
module dnle_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0]
      && (m_axis_tdata == 16'h0000))
    else $error("error result malformed");

  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("terminator without last");

  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:8] == 8'h00))
    else $error("second byte not zero");

  // No character is taken while a result is stalled.
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && s_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted while result stalled");

endmodule

bind dns_name_label_encoder_top dnle_chk u_dnle_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

[tb/sv/dns_name_label_encoder_top_tb.sv]
// Testbench for the DNS name label encoder: directed and random names, scoreboarded per result transaction.
module dns_name_label_encoder_top_tb;
  import dnle_pkg::*;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] character
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] first_byte, [15:8] second_byte
  logic [1:0]  m_axis_tuser;           // [0] second_valid, [1] label_error
  logic        m_axis_tlast;

  dns_name_label_encoder_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Pending characters and expected results
  logic [7:0] char_q[$];
  res_t       wire_q[$];

  // Encoder state mirror
  logic [7:0] label_buf [STORE_DEPTH];
  logic [5:0] lbl_cnt   = '0;
  logic       dropping  = 1'b0;

  int err_count       = 0;
  int items_queued    = 0;
  int chars_accepted  = 0;
  int results_checked = 0;
  int names_seen      = 0;
  int overlong_seen   = 0;
  int longest_label   = 0;

  logic char_taken = 1'b0;
  logic res_taken  = 1'b0;
  int   send_gap   = 0;
  int   recv_wait  = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 10)) : 0;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic void push_wire(logic [7:0] b0, logic [7:0] b1, logic sv, logic err,
                                    logic lst);
    res_t r;
    r.first_byte   = b0;
    r.second_byte  = b1;
    r.second_valid = sv;
    r.label_error  = err;
    r.last         = lst;
    wire_q.push_back(r);
  endfunction

  // Length byte, then the buffered characters; at the end of a name the terminator rides on the last one
  function automatic void emit_label(logic ending);
    logic fin;
    push_wire(8'(lbl_cnt), 8'h00, 1'b0, 1'b0, 1'b0);
    if (int'(lbl_cnt) > longest_label) longest_label = int'(lbl_cnt);
    for (int i = 0; i < int'(lbl_cnt); i++) begin
      fin = ending && (i == int'(lbl_cnt) - 1);
      push_wire(label_buf[i], 8'h00, fin, 1'b0, fin);
    end
    lbl_cnt = '0;
  endfunction

  function automatic void encode_char(logic [7:0] ch);
    if (dropping) begin
      if (ch == END_CHAR) begin
        dropping = 1'b0;
        lbl_cnt  = '0;
      end
    end else if (ch == END_CHAR) begin
      names_seen++;
      if (lbl_cnt != 0) emit_label(1'b1);
      else push_wire(8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
    end else if (ch == DOT_CHAR) begin
      if (lbl_cnt != 0) emit_label(1'b0);
    end else if (lbl_cnt >= MAX_LABEL) begin
      // overlong label: single error transaction, rest of the name dropped
      lbl_cnt  = '0;
      dropping = 1'b1;
      overlong_seen++;
      push_wire(8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
    end else begin
      label_buf[lbl_cnt] = ch;
      lbl_cnt            = lbl_cnt + 6'd1;
    end
  endfunction

  task automatic check_result();
    res_t want;
    results_checked++;
    if (wire_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                                m_axis_tdata, m_axis_tuser, m_axis_tlast));
    end else begin
      want = wire_q.pop_front();
      if (m_axis_tdata[7:0] !== want.first_byte)
        report_mismatch($sformatf("first_byte got %h exp %h", m_axis_tdata[7:0],
                                  want.first_byte));
      if (m_axis_tdata[15:8] !== want.second_byte)
        report_mismatch($sformatf("second_byte got %h exp %h", m_axis_tdata[15:8],
                                  want.second_byte));
      if (m_axis_tuser[0] !== want.second_valid)
        report_mismatch($sformatf("second_valid got %b exp %b", m_axis_tuser[0],
                                  want.second_valid));
      if (m_axis_tuser[1] !== want.label_error)
        report_mismatch($sformatf("label_error got %b exp %b", m_axis_tuser[1],
                                  want.label_error));
      if (m_axis_tlast !== want.last)
        report_mismatch($sformatf("last got %b exp %b", m_axis_tlast, want.last));
    end
  endtask

  // Monitor: prediction before checking, in case both happen on one edge
  always @(posedge clk_i) begin
    char_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    res_taken  <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      encode_char(s_axis_tdata);
      chars_accepted++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
  end

  // Character driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
    end else if (s_axis_tvalid && !char_taken) begin
      // hold until the transaction completes
    end else if (send_gap > 0) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= send_gap - 1;
    end else if (char_q.size() > 0) begin
      s_axis_tdata  <= char_q.pop_front();
      s_axis_tvalid <= 1'b1;
      send_gap      <= draw_gap();
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Result sink: random stall after each transaction
  always @(negedge clk_i) begin : sink_drv
    int w;
    w = res_taken ? draw_gap() : recv_wait;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait     <= 0;
    end else if (w > 0) begin
      m_axis_tready <= 1'b0;
      recv_wait     <= w - 1;
    end else begin
      m_axis_tready <= 1'b1;
      recv_wait     <= 0;
    end
  end

  task automatic add_char(logic [7:0] c);
    char_q.push_back(c);
    items_queued++;
  endtask

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == DOT_CHAR);
    return c;
  endfunction

  task automatic add_label(int len);
    repeat (len) add_char(label_char());
  endtask

  // One random name; used counts characters that are not simply discarded
  task automatic gen_name(output int used);
    int nlab;
    int len;
    used = 0;
    if ($urandom_range(0, 7) == 0) begin
      add_char(DOT_CHAR);
      used++;
    end
    nlab = $urandom_range(0, 4);
    for (int k = 0; k < nlab; k++) begin
      len = ($urandom_range(0, 24) == 0) ? int'($urandom_range(60, 66))
                                         : int'($urandom_range(1, 8));
      add_label(len);
      if (len > MAX_LABEL) begin
        used += MAX_LABEL + 1;
        repeat ($urandom_range(0, 4)) add_char(8'($urandom_range(1, 255)));
        break;
      end
      used += len;
      if (k < nlab - 1 || $urandom_range(0, 5) == 0) begin
        add_char(DOT_CHAR);
        used++;
        if ($urandom_range(0, 5) == 0) begin
          add_char(DOT_CHAR);
          used++;
        end
      end
    end
    add_char(END_CHAR);
    used++;
  endtask

  task automatic wait_drained();
    while (chars_accepted != items_queued || wire_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic gen_random(int target);
    int got;
    int n;
    got = 0;
    while (got < target) begin
      if ($urandom_range(0, 19) == 0) begin
        // noise: any byte, dots and zeros included
        repeat ($urandom_range(1, 6)) begin
          add_char(8'($urandom_range(0, 255)));
          got++;
        end
      end else begin
        gen_name(n);
        got += n;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty name, lone dot, extreme characters
    add_char(END_CHAR);
    add_char(DOT_CHAR);
    add_char(END_CHAR);
    add_char(8'hFF);
    add_char(DOT_CHAR);
    add_char(8'h01);
    add_char(END_CHAR);
    // leading, repeated and trailing dots
    add_char(DOT_CHAR);
    add_char(DOT_CHAR);
    add_char(8'h78);
    add_char(DOT_CHAR);
    add_char(DOT_CHAR);
    add_char(8'h79);
    add_char(DOT_CHAR);
    add_char(END_CHAR);
    // bit patterns
    add_char(8'h80);
    add_char(8'h7F);
    add_char(8'h55);
    add_char(8'hAA);
    add_char(END_CHAR);
    wait_drained();

    // full-length label, then an overlong one after an emitted label
    add_label(MAX_LABEL);
    add_char(DOT_CHAR);
    add_label(2);
    add_char(END_CHAR);
    add_label(3);
    add_char(DOT_CHAR);
    add_label(MAX_LABEL + 1);
    add_char(DOT_CHAR);
    add_char(8'h41);
    add_char(END_CHAR);

    gen_random(170);
    wait_drained();
    gen_random(170);
    wait_drained();
    repeat (80) @(posedge clk_i);

    if (wire_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", wire_q.size()));
    $display("Summary: %0d characters, %0d names, %0d results checked",
             chars_accepted, names_seen, results_checked);
    $display("Summary: %0d overlong labels, longest emitted label %0d",
             overlong_seen, longest_label);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout: %0d characters accepted of %0d, %0d results pending",
             chars_accepted, items_queued, wire_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
rtl/core/dnle_pkg.sv
rtl/core/dnle_ram.sv
rtl/core/dnle_dp.sv
rtl/core/dnle_ctrl.sv
rtl/core/dns_name_label_encoder_top.sv
rtl/core/dnle_chk.sv
tb/sv/dns_name_label_encoder_top_tb.sv
